// ===== hdl/ppc_pkg.sv =====
`default_nettype none
package ppc_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 32;
    localparam int CORDIC_STEPS   = 24;

    localparam logic [18:0] FWD_OFFSET_RST = 19'd23593;
    localparam logic [9:0]  WP_DIV_RST     = 10'd100;

    localparam logic [1:0] REG_FWD_OFFSET = 2'd0;
    localparam logic [1:0] REG_WP_DIV     = 2'd1;
    localparam logic [1:0] REG_INIT_X     = 2'd2;
    localparam logic [1:0] REG_INIT_Y     = 2'd3;

    typedef struct packed {
        logic [31:0]        timestamp;
        logic               has_waypoint;
        logic signed [31:0] waypoint_x;
        logic signed [31:0] waypoint_y;
        logic               has_pose;
        logic signed [31:0] rear_x;
        logic signed [31:0] rear_y;
        logic signed [15:0] rear_heading;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        stamp_out;
        logic signed [31:0] curvature;
        logic               degenerate;
    } out_item_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_DIV_INIT = 4'd2,
        OP_DIV_STEP = 4'd3,
        OP_SC_WP    = 4'd4,
        OP_SC_POSE  = 4'd5,
        OP_SC_STEP  = 4'd6,
        OP_SC_DONE  = 4'd7,
        OP_WP_DIFF  = 4'd8,
        OP_WP_MUL   = 4'd9,
        OP_WP_SUM   = 4'd10,
        OP_POSE_MUL = 4'd11,
        OP_POSE_SUM = 4'd12,
        OP_CV_INIT  = 4'd13,
        OP_CV_STEP  = 4'd14,
        OP_CV_DONE  = 4'd15
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [5:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic has_waypoint;
        logic has_pose;
        logic den_mul_done;
    } dp_stat_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ppc_ctrl.sv =====
`default_nettype none
module ppc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire ppc_pkg::dp_stat_t stat,
    output ppc_pkg::dp_cmd_t       cmd
);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b000000000001,
        ST_DIV     = 12'b000000000010,
        ST_SC_WP   = 12'b000000000100,
        ST_WP_DIFF = 12'b000000001000,
        ST_WP_MUL  = 12'b000000010000,
        ST_WP_SUM  = 12'b000000100000,
        ST_SC_PO   = 12'b000001000000,
        ST_PO_MUL  = 12'b000010000000,
        ST_PO_SUM  = 12'b000100000000,
        ST_CV_INIT = 12'b001000000000,
        ST_CV      = 12'b010000000000,
        ST_OUT     = 12'b100000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 6'd1;
        cmd.op     = ppc_pkg::OP_NONE;
        cmd.step   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    cmd.op     = ppc_pkg::OP_LOAD;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // 32 restoring steps after an init step; both axes in parallel
                if (!stat.has_waypoint) begin
                    state_next = ST_SC_PO;
                    cnt_next   = '0;
                end else if (cnt_reg == 6'd0) begin
                    cmd.op = ppc_pkg::OP_DIV_INIT;
                end else begin
                    cmd.op = ppc_pkg::OP_DIV_STEP;
                    if (cnt_reg == 6'd32) begin
                        state_next = ST_SC_WP;
                        cnt_next   = '0;
                    end
                end
            end
            ST_SC_WP, ST_SC_PO: begin
                if (cnt_reg == 6'd0) begin
                    cmd.op = (state_reg == ST_SC_WP) ? ppc_pkg::OP_SC_WP
                                                     : ppc_pkg::OP_SC_POSE;
                    if (state_reg == ST_SC_PO && !stat.has_pose) begin
                        cmd.op     = ppc_pkg::OP_NONE;
                        state_next = ST_CV_INIT;
                    end
                end else if (cnt_reg <= 6'd24) begin
                    cmd.op   = ppc_pkg::OP_SC_STEP;
                    cmd.step = cnt_reg - 6'd1;
                end else begin
                    cmd.op     = ppc_pkg::OP_SC_DONE;
                    state_next = (state_reg == ST_SC_WP) ? ST_WP_DIFF : ST_PO_MUL;
                end
            end
            ST_WP_DIFF: begin
                cmd.op     = ppc_pkg::OP_WP_DIFF;
                state_next = ST_WP_MUL;
            end
            ST_WP_MUL: begin
                cmd.op     = ppc_pkg::OP_WP_MUL;
                state_next = ST_WP_SUM;
            end
            ST_WP_SUM: begin
                cmd.op     = ppc_pkg::OP_WP_SUM;
                state_next = ST_SC_PO;
                cnt_next   = '0;
            end
            ST_PO_MUL: begin
                cmd.op     = ppc_pkg::OP_POSE_MUL;
                state_next = ST_PO_SUM;
            end
            ST_PO_SUM: begin
                cmd.op     = ppc_pkg::OP_POSE_SUM;
                state_next = ST_CV_INIT;
            end
            ST_CV_INIT: begin
                // squares are formed over the mph_reg phases; wait for den_mul_done
                cmd.op = ppc_pkg::OP_CV_INIT;
                if (stat.den_mul_done) begin
                    state_next = ST_CV;
                    cnt_next   = '0;
                end
            end
            ST_CV: begin
                if (cnt_reg <= 6'd31) begin
                    cmd.op   = ppc_pkg::OP_CV_STEP;
                    cmd.step = 6'd31 - cnt_reg;
                end else begin
                    cmd.op     = ppc_pkg::OP_CV_DONE;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ppc_datapath.sv =====
`default_nettype none
module ppc_datapath #(
    parameter int ANGLE_BITS = ppc_pkg::ANGLE_BITS_DEF,
    parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ppc_pkg::in_item_t  s_item,
    input  wire ppc_pkg::dp_cmd_t   cmd,
    output ppc_pkg::dp_stat_t       stat,
    output ppc_pkg::out_item_t      m_item,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_idx,
    input  wire logic [31:0]        cfg_wdata,
    output logic [31:0]             cfg_rdata
);
    localparam int CB = COORD_BITS;
    localparam int PB = CB + 20;          // product width, coord x Q16 trig
    localparam int AB = ANGLE_BITS;
    localparam int DB = 2 * CB + 2;       // curvature remainder width

    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

    // configuration
    logic [18:0] fwd_reg;
    logic [9:0]  div_reg;
    logic [31:0] ilx_reg, ily_reg;

    // state
    logic signed [CB-1:0] pose_x_reg, pose_y_reg, look_x_reg, look_y_reg;
    logic signed [AB-1:0] head_reg;

    // item
    ppc_pkg::in_item_t    it_reg;

    // divider
    logic [31:0] qx_reg, qy_reg, rx_reg, ry_reg;

    // cordic
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic               cneg_reg;
    logic signed [17:0] sin_reg, cos_reg;

    // transform
    logic signed [CB:0]   dx_reg, dy_reg;
    logic signed [PB-1:0] p0_reg, p1_reg, p2_reg, p3_reg;

    // curvature
    logic [CB-1:0]        ax_reg, ay_reg;
    logic [DB-1:0]        den_reg, num_reg;
    logic [2:0]           mph_reg;
    logic [31:0]          q_reg;
    logic                 sat_reg, degen_reg, neg_reg, pos_reg;

    function automatic logic signed [CB-1:0] sat_c(input logic signed [PB:0] v);
        if (v > $signed({{(PB+1-CB){1'b0}}, CMAX})) return CMAX;
        if (v < $signed({{(PB+1-CB){1'b1}}, CMIN})) return CMIN;
        return v[CB-1:0];
    endfunction

    assign stat.has_waypoint = it_reg.has_waypoint;
    assign stat.has_pose     = it_reg.has_pose;
    assign stat.den_mul_done = (mph_reg == 3'd4);

    always_comb begin
        unique case (cfg_idx)
            ppc_pkg::REG_FWD_OFFSET: cfg_rdata = {13'd0, fwd_reg};
            ppc_pkg::REG_WP_DIV:     cfg_rdata = {22'd0, div_reg};
            ppc_pkg::REG_INIT_X:     cfg_rdata = ilx_reg;
            ppc_pkg::REG_INIT_Y:     cfg_rdata = ily_reg;
            default:                 cfg_rdata = '0;
        endcase
    end

    // combinational helpers
    logic [31:0] wax, way, dv;
    logic [32:0] rxs, rys;
    logic signed [31:0] xs, ys;
    logic [31:0] ang;
    logic signed [AB-1:0] hnew;
    logic signed [31:0] crx, cry;
    logic signed [17:0] crx_c, cry_c;
    logic [DB+30:0] dsh;
    logic signed [CB-1:0] lx, ly;

    always_comb begin
        wax = it_reg.waypoint_x[31] ? 32'(-it_reg.waypoint_x) : it_reg.waypoint_x;
        way = it_reg.waypoint_y[31] ? 32'(-it_reg.waypoint_y) : it_reg.waypoint_y;
        dv  = (div_reg == '0) ? 32'd1 : {22'd0, div_reg};
        rxs = {rx_reg, qx_reg[31]} - {1'b0, dv};
        rys = {ry_reg, qy_reg[31]} - {1'b0, dv};
        xs  = cx_reg >>> cmd.step[4:0];
        ys  = cy_reg >>> cmd.step[4:0];
        if (AB >= 16) hnew = AB'($signed(it_reg.rear_heading)) <<< (AB - 16);
        else          hnew = AB'($signed(it_reg.rear_heading) >>> (16 - AB));
        if (cmd.op == ppc_pkg::OP_SC_WP) ang = 32'({head_reg, {(32-AB){1'b0}}});
        else                             ang = 32'({hnew, {(32-AB){1'b0}}});
        crx = (cx_reg + 32'sd8192) >>> 14;
        cry = (cy_reg + 32'sd8192) >>> 14;
        if (cneg_reg) begin
            crx = -crx;
            cry = -cry;
        end
        crx_c = (crx > 32'sd65536) ? 18'sd65536 :
                (crx < -32'sd65536) ? -18'sd65536 : crx[17:0];
        cry_c = (cry > 32'sd65536) ? 18'sd65536 :
                (cry < -32'sd65536) ? -18'sd65536 : cry[17:0];
        // shifted divisor kept at full width so high bits are not lost
        dsh = {31'd0, den_reg} << cmd.step[4:0];
        lx  = look_x_reg;
        ly  = look_y_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg    <= ppc_pkg::FWD_OFFSET_RST;
            div_reg    <= ppc_pkg::WP_DIV_RST;
            ilx_reg    <= '0;
            ily_reg    <= '0;
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            head_reg   <= '0;
            look_x_reg <= '0;
            look_y_reg <= '0;
            mph_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                ppc_pkg::REG_FWD_OFFSET: fwd_reg <= cfg_wdata[18:0];
                ppc_pkg::REG_WP_DIV:     div_reg <= cfg_wdata[9:0];
                ppc_pkg::REG_INIT_X: begin
                    ilx_reg    <= cfg_wdata;
                    look_x_reg <= sat_c(PB'($signed(cfg_wdata)));
                end
                ppc_pkg::REG_INIT_Y: begin
                    ily_reg    <= cfg_wdata;
                    look_y_reg <= sat_c(PB'($signed(cfg_wdata)));
                end
                default: ;
            endcase
        end else begin
            unique case (cmd.op)
                ppc_pkg::OP_LOAD: it_reg <= s_item;
                ppc_pkg::OP_DIV_INIT: begin
                    qx_reg <= wax;
                    qy_reg <= way;
                    rx_reg <= '0;
                    ry_reg <= '0;
                end
                ppc_pkg::OP_DIV_STEP: begin
                    if (!rxs[32]) begin
                        rx_reg <= rxs[31:0];
                        qx_reg <= {qx_reg[30:0], 1'b1};
                    end else begin
                        rx_reg <= {rx_reg[30:0], qx_reg[31]};
                        qx_reg <= {qx_reg[30:0], 1'b0};
                    end
                    if (!rys[32]) begin
                        ry_reg <= rys[31:0];
                        qy_reg <= {qy_reg[30:0], 1'b1};
                    end else begin
                        ry_reg <= {ry_reg[30:0], qy_reg[31]};
                        qy_reg <= {qy_reg[30:0], 1'b0};
                    end
                end
                ppc_pkg::OP_SC_WP, ppc_pkg::OP_SC_POSE: begin
                    if (cmd.op == ppc_pkg::OP_SC_POSE) head_reg <= hnew;
                    cneg_reg <= (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
                    if ((ang[31:30] == 2'd1) || (ang[31:30] == 2'd2))
                        cz_reg <= $signed(ang + 32'h8000_0000);
                    else
                        cz_reg <= $signed(ang);
                    cx_reg <= 32'sd652032874;
                    cy_reg <= '0;
                end
                ppc_pkg::OP_SC_STEP: begin
                    if (!cz_reg[31]) begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - $signed(ppc_pkg::atan_entry(cmd.step[4:0]));
                    end else begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + $signed(ppc_pkg::atan_entry(cmd.step[4:0]));
                    end
                end
                ppc_pkg::OP_SC_DONE: begin
                    cos_reg <= crx_c;
                    sin_reg <= cry_c;
                end
                ppc_pkg::OP_WP_DIFF: begin
                    dx_reg <= (CB+1)'(sat_c(PB'($signed({1'b0, qx_reg}))
                                            - PB'(pose_x_reg)));
                    dy_reg <= (CB+1)'(sat_c(PB'($signed({1'b0, qy_reg}))
                                            - PB'(pose_y_reg)));
                end
                ppc_pkg::OP_WP_MUL: begin
                    p0_reg <= PB'(dx_reg * sin_reg) >>> 16;
                    p1_reg <= PB'(dy_reg * cos_reg) >>> 16;
                    p2_reg <= PB'(dx_reg * cos_reg) >>> 16;
                    p3_reg <= PB'(dy_reg * sin_reg) >>> 16;
                end
                ppc_pkg::OP_WP_SUM: begin
                    look_x_reg <= sat_c((PB+1)'(p0_reg) - (PB+1)'(p1_reg));
                    look_y_reg <= sat_c((PB+1)'(p2_reg) + (PB+1)'(p3_reg));
                end
                ppc_pkg::OP_POSE_MUL: begin
                    p0_reg <= PB'($signed({1'b0, fwd_reg}) * cos_reg) >>> 16;
                    p1_reg <= PB'($signed({1'b0, fwd_reg}) * sin_reg) >>> 16;
                end
                ppc_pkg::OP_POSE_SUM: begin
                    pose_x_reg <= sat_c((PB+1)'($signed(it_reg.rear_x)) + (PB+1)'(p0_reg));
                    pose_y_reg <= sat_c((PB+1)'($signed(it_reg.rear_y)) + (PB+1)'(p1_reg));
                end
                ppc_pkg::OP_CV_INIT: begin
                    // latch |lx| and |ly|, then ax^2 then ay^2, one square per cycle while cfg_we is low
                    unique case (mph_reg)
                        3'd0: begin
                            ax_reg    <= lx[CB-1] ? CB'(-lx) : lx;
                            ay_reg    <= ly[CB-1] ? CB'(-ly) : ly;
                            degen_reg <= (lx == '0) && (ly == '0);
                            neg_reg   <= lx[CB-1];
                            pos_reg   <= !lx[CB-1] && (lx != '0);
                            mph_reg   <= 3'd1;
                        end
                        3'd1: begin
                            den_reg <= DB'(ax_reg) * DB'(ax_reg);
                            mph_reg <= 3'd2;
                        end
                        3'd2: begin
                            den_reg <= den_reg + DB'(ay_reg) * DB'(ay_reg);
                            num_reg <= DB'(ax_reg) << 33;
                            mph_reg <= 3'd3;
                        end
                        3'd3: begin
                            sat_reg <= {31'd0, num_reg} >= {den_reg, 31'd0};
                            q_reg   <= '0;
                            mph_reg <= 3'd4;
                        end
                        default: mph_reg <= 3'd0;
                    endcase
                end
                ppc_pkg::OP_CV_STEP: begin
                    mph_reg <= '0;
                    if ({31'd0, num_reg} >= dsh) begin
                        num_reg <= num_reg - dsh[DB-1:0];
                        q_reg[cmd.step[4:0]] <= 1'b1;
                    end
                end
                ppc_pkg::OP_CV_DONE: begin
                    m_item.stamp_out  <= it_reg.timestamp;
                    m_item.degenerate <= degen_reg;
                    if (degen_reg)
                        m_item.curvature <= '0;
                    else if (sat_reg)
                        m_item.curvature <= pos_reg ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                    else
                        m_item.curvature <= neg_reg ? -$signed(q_reg) : $signed(q_reg);
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pure_pursuit_curvature_core.sv =====
// The sequence is set by the 32-step restoring divider and a 24-step CORDIC run when a
// waypoint is given, a second 24-step CORDIC run when a pose is given, and the 32-step
// curvature divider, all in one shared sequential datapath.
// Throughput: one item at a time; next item taken after the result is accepted.
// Reset (aresetn low, synchronous): registers to defaults, pose and lookahead to 0.
`default_nettype none
module pure_pursuit_curvature_core #(
    parameter int ANGLE_BITS = ppc_pkg::ANGLE_BITS_DEF,
    parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ppc_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ppc_pkg::out_item_t      m_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    ppc_pkg::dp_cmd_t  cmd;
    ppc_pkg::dp_stat_t stat;
    logic              cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    ppc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ppc_datapath #(
        .ANGLE_BITS (ANGLE_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cmd       (cmd),
        .stat      (stat),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_idx   (paddr[3:2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata)
    );

endmodule
`default_nettype wire

// ===== hdl/ppc_checker.sv =====
`default_nettype none
module ppc_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic pready
);
    // only one item in flight
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready after accept");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind pure_pursuit_curvature_core ppc_checker u_chk (
    .aclk (aclk), .aresetn (aresetn), .s_valid (s_valid), .s_ready (s_ready),
    .m_valid (m_valid), .m_ready (m_ready), .pready (pready)
);
`default_nettype wire

// ===== tb/pure_pursuit_curvature_core_tb.sv =====
`timescale 1ns / 100ps
module pure_pursuit_curvature_core_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 160;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 55;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         reg_idx;
        logic [31:0]        reg_val;
        ppc_pkg::in_item_t  item;
        bit                 typed;
        logic [31:0]        curv;
        logic               degen;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ppc_pkg::in_item_t  s_item = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ppc_pkg::out_item_t m_item;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // shadow of block state and registers
    longint      fwd_offset, wp_divisor;
    longint      pose_x, pose_y, pose_hdg, look_x, look_y;

    ppc_pkg::out_item_t curv_expect_q[$];
    stim_row_t   rows[$];
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_results = 0;
    int          n_degen = 0;
    int          n_sat = 0;
    int          idle_cycles = 0;
    int          long_hold = 0;
    bit          long_hold_done = 0;
    int unsigned cyc = 0;

    always #4 aclk = ~aclk;

    pure_pursuit_curvature_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic sin_cos(input longint hdg, output longint s, output longint c);
        logic [31:0] a;
        bit          neg;
        longint      x, y, z, xs, ys;
        a = {hdg[15:0], 16'h0};
        neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (neg) a = a + 32'h8000_0000;
        z = $signed(a);
        x = 652032874;
        y = 0;
        for (int i = 0; i < ppc_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(ppc_pkg::atan_entry(i[4:0]));
            end else begin
                x += ys; y -= xs; z += longint'(ppc_pkg::atan_entry(i[4:0]));
            end
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        if (neg) begin
            x = -x; y = -y;
        end
        c = (x > 65536) ? 65536 : (x < -65536) ? -65536 : x;
        s = (y > 65536) ? 65536 : (y < -65536) ? -65536 : y;
    endtask

    task automatic curvature_of(input longint x, input longint y,
                                output logic [31:0] curv, output logic degen);
        logic [127:0] ax, ay, den, num, t;
        logic [31:0]  q;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        degen = (x == 0) && (y == 0);
        curv = '0;
        if (!degen) begin
            den = ax * ax + ay * ay;
            num = ax << 33;
            if (num >= (den << 31)) begin
                curv = (x > 0) ? 32'h7fff_ffff : 32'h8000_0000;
            end else begin
                q = '0;
                for (int k = 30; k >= 0; k--) begin
                    t = den << k;
                    if (num >= t) begin
                        num = num - t;
                        q[k] = 1'b1;
                    end
                end
                curv = (x < 0) ? -q : q;
            end
        end
    endtask

    task automatic predict_curvature(input ppc_pkg::in_item_t it,
                                     output ppc_pkg::out_item_t r);
        longint s, c, mx, my, dx, dy, wx, wy, dv;
        if (it.has_waypoint) begin
            dv = (wp_divisor == 0) ? 1 : wp_divisor;
            wx = longint'(it.waypoint_x);
            wy = longint'(it.waypoint_y);
            mx = ((wx < 0) ? -wx : wx) / dv;
            my = ((wy < 0) ? -wy : wy) / dv;
            sin_cos(pose_hdg, s, c);
            dx = sat32(mx - pose_x);
            dy = sat32(my - pose_y);
            look_x = sat32(((dx * s) >>> 16) - ((dy * c) >>> 16));
            look_y = sat32(((dx * c) >>> 16) + ((dy * s) >>> 16));
        end
        if (it.has_pose) begin
            pose_hdg = longint'(it.rear_heading);
            sin_cos(pose_hdg, s, c);
            pose_x = sat32(longint'(it.rear_x) + ((fwd_offset * c) >>> 16));
            pose_y = sat32(longint'(it.rear_y) + ((fwd_offset * s) >>> 16));
        end
        r.stamp_out = it.timestamp;
        curvature_of(look_x, look_y, r.curvature, r.degenerate);
    endtask

    task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
        n_errors++;
        $display("MISMATCH %s: expected %0h, got %0h (result %0d)", what, exp_v, got_v,
                 n_results);
    endtask

    // result checker
    always @(posedge aclk) begin
        ppc_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (curv_expect_q.size() == 0) begin
                report("unexpected item", 32'h0, m_item.curvature);
            end else begin
                e = curv_expect_q.pop_front();
                if (m_item.stamp_out !== e.stamp_out)
                    report("stamp_out", e.stamp_out, m_item.stamp_out);
                if (m_item.curvature !== e.curvature)
                    report("curvature", e.curvature, m_item.curvature);
                if (m_item.degenerate !== e.degenerate)
                    report("degenerate", 32'(e.degenerate), 32'(m_item.degenerate));
                if (e.degenerate) n_degen++;
                if (e.curvature == 32'h7fff_ffff || e.curvature == 32'h8000_0000) n_sat++;
            end
            n_results++;
        end
    end

    // receiver: random stalls, calm stretches, one long hold-off
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            m_ready <= 1'b0;
        end else if (!long_hold_done && n_results == 60) begin
            long_hold_done <= 1'b1;
            long_hold <= 400;
            m_ready <= 1'b0;
        end else if (cyc[9]) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // setup, access, then an idle wait so back-to-back writes stay apart
    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ppc_pkg::REG_FWD_OFFSET: fwd_offset = longint'(val[18:0]);
            ppc_pkg::REG_WP_DIV:     wp_divisor = longint'(val[9:0]);
            ppc_pkg::REG_INIT_X:     look_x = longint'($signed(val));
            default:                 look_y = longint'($signed(val));
        endcase
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (curv_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // drive one item; returns at the edge where it was taken
    task automatic send_item(ppc_pkg::in_item_t it, bit typed, logic [31:0] curv,
                             logic degen);
        ppc_pkg::out_item_t r;
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        predict_curvature(it, r);
        if (typed) begin
            r.curvature = curv;
            r.degenerate = degen;
        end
        curv_expect_q.push_back(r);
        n_sent++;
    endtask

    function automatic ppc_pkg::in_item_t mk(bit hw, int wx, int wy, bit hp, int rx,
                                             int ry, shortint hd);
        ppc_pkg::in_item_t it;
        it.timestamp = $urandom;
        it.has_waypoint = hw;
        it.waypoint_x = wx;
        it.waypoint_y = wy;
        it.has_pose = hp;
        it.rear_x = rx;
        it.rear_y = ry;
        it.rear_heading = hd;
        return it;
    endfunction

    function automatic int rand_coord();
        int v;
        if ($urandom_range(0, 2) == 0) return int'($urandom);
        v = int'($urandom_range(0, 32'h0040_0000));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic add_cfg(logic [1:0] idx, logic [31:0] val);
        stim_row_t r;
        r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, item: '0, typed: 0,
              curv: '0, degen: 1'b0};
        rows.push_back(r);
    endtask

    task automatic add_item(ppc_pkg::in_item_t it, bit typed = 0, logic [31:0] curv = '0,
                            logic degen = 1'b0);
        stim_row_t r;
        r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, item: it, typed: typed,
              curv: curv, degen: degen};
        rows.push_back(r);
    endtask

    initial begin
        ppc_pkg::in_item_t it;
        int                burst, gap;

        fwd_offset = ppc_pkg::FWD_OFFSET_RST;
        wp_divisor = ppc_pkg::WP_DIV_RST;
        pose_x = 0; pose_y = 0; pose_hdg = 0; look_x = 0; look_y = 0;

        // lookahead at origin after reset, then curvature extremes from register loads
        add_item(mk(0, 0, 0, 0, 0, 0, 0), 1, 32'd0, 1'b1);
        add_cfg(ppc_pkg::REG_INIT_X, 32'd65536);
        add_item(mk(0, 0, 0, 0, 0, 0, 0), 1, 32'd131072, 1'b0);
        add_cfg(ppc_pkg::REG_INIT_X, -32'sd65536);
        add_item(mk(0, 0, 0, 0, 0, 0, 0), 1, -32'sd131072, 1'b0);
        add_cfg(ppc_pkg::REG_INIT_X, 32'd1);
        add_item(mk(0, 0, 0, 0, 0, 0, 0), 1, 32'h7fff_ffff, 1'b0);
        add_cfg(ppc_pkg::REG_INIT_X, 32'hffff_ffff);
        add_item(mk(0, 0, 0, 0, 0, 0, 0), 1, 32'h8000_0000, 1'b0);
        add_cfg(ppc_pkg::REG_INIT_X, 32'd0);
        add_cfg(ppc_pkg::REG_INIT_Y, 32'd65536);
        add_item(mk(0, 0, 0, 0, 0, 0, 0), 1, 32'd0, 1'b0);
        // waypoint and pose extremes, through the predictor
        add_item(mk(1, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0));
        add_item(mk(1, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h7fff_ffff, 32'h8000_0000,
                    16'sh7fff));
        add_item(mk(0, 0, 0, 1, 32'h8000_0000, 32'h7fff_ffff, -16'sh8000));
        add_item(mk(1, 32'd6553600, 32'd0, 1, 0, 0, 16'sd16384));
        add_item(mk(1, 32'd0, 32'd6553600, 1, 32'd65536, 0, -16'sd16384));
        add_cfg(ppc_pkg::REG_WP_DIV, 32'd0);
        add_cfg(ppc_pkg::REG_FWD_OFFSET, 32'd262144);
        add_item(mk(1, 32'd200000, -32'sd300000, 1, 0, 0, 16'sd0));
        add_item(mk(1, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
        add_cfg(ppc_pkg::REG_WP_DIV, 32'd1000);
        add_cfg(ppc_pkg::REG_FWD_OFFSET, 32'd0);
        add_item(mk(1, 32'h7fff_ffff, 32'd12345, 1, 32'd1000, -32'sd1000, 16'sd8192));
        add_item(mk(1, -32'sd5000000, 32'd5000000, 0, 0, 0, 0));
        add_cfg(ppc_pkg::REG_WP_DIV, 32'd1);
        add_item(mk(1, 32'd0, 32'd0, 1, 0, 0, -16'sd1));
        add_item(mk(1, 32'd0, 32'd0, 0, 0, 0, 0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                send_item(rows[i].item, rows[i].typed, rows[i].curv, rows[i].degen);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    cfg_write(ppc_pkg::REG_FWD_OFFSET, 32'd0);
                    cfg_write(ppc_pkg::REG_WP_DIV, 32'd1);
                end
                1: begin
                    cfg_write(ppc_pkg::REG_FWD_OFFSET, 32'h7ffff);
                    cfg_write(ppc_pkg::REG_WP_DIV, 32'h3ff);
                end
                default: begin
                    cfg_write(ppc_pkg::REG_FWD_OFFSET, $urandom_range(0, 262144));
                    cfg_write(ppc_pkg::REG_WP_DIV, $urandom_range(1, 1000));
                end
            endcase
            cfg_write(ppc_pkg::REG_INIT_X, (ph == 3) ? 32'h8000_0000 : $urandom);
            cfg_write(ppc_pkg::REG_INIT_Y, (ph == 3) ? 32'h7fff_ffff : rand_coord());
            for (int n = 0; n < PHASE_ITEMS; n += burst) begin
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst; b++) begin
                    it = mk($urandom_range(0, 1), rand_coord(), rand_coord(),
                            $urandom_range(0, 1), rand_coord(), rand_coord(),
                            shortint'($urandom));
                    send_item(it, 0, '0, 1'b0);
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end

        wait_idle();
        $display("Ran %0d items (%0d results, %0d at origin, %0d saturated) over %0d settings",
                 n_sent, n_results, n_degen, n_sat, RAND_PHASES + 1);
        $display("Receiver held off once for 400 cycles; %0d mismatches", n_errors);
        if (n_errors == 0 && curv_expect_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
